/* design/planter_pump_and_light_controller_assert.svh */
// Assertion macros for the planter pump and light controller checker.
`ifndef PLANTER_PUMP_AND_LIGHT_CONTROLLER_ASSERT_SVH
`define PLANTER_PUMP_AND_LIGHT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/plc_pkg.sv */
// Types, constants and helpers shared by the planter controller modules.
package plc_pkg;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;
    localparam int THRESH_W   = 12;

    typedef enum logic [1:0] {
        REG_THRESH_LOW  = 2'd0,
        REG_THRESH_MED  = 2'd1,
        REG_THRESH_HIGH = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_LOW    = 2'd1,
        MODE_MEDIUM = 2'd2,
        MODE_HIGH   = 2'd3
    } water_mode_t;

    typedef enum logic {
        FUNC_STEP = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    localparam logic [THRESH_W-1:0] THRESH_LOW_RST  = 12'd3000;
    localparam logic [THRESH_W-1:0] THRESH_MED_RST  = 12'd2300;
    localparam logic [THRESH_W-1:0] THRESH_HIGH_RST = 12'd1800;

    localparam logic [4:0] REST_LAST = 5'd15;
    localparam logic [4:0] RUN_LAST  = 5'd2;

    // floor(v * 1000 / 255) as a multiply by a rounded-up reciprocal
    localparam int          DUTY_SHIFT = 20;
    localparam logic [21:0] DUTY_RECIP = 22'd4112157;

    typedef struct packed {
        func_t       func;
        logic [11:0] moisture;
        water_mode_t water_mode;
        logic        pump_request;
        logic        light_request;
        logic [3:0]  countdown_hours;
        logic [7:0]  red_level;
        logic [7:0]  green_level;
        logic [7:0]  blue_level;
        logic [7:0]  warm_level;
    } item_t;

    function automatic logic [9:0] duty_of(input logic [7:0] lvl);
        logic [29:0] prod;
        prod = 30'(lvl) * 30'(DUTY_RECIP);
        return prod[DUTY_SHIFT +: 10];
    endfunction

endpackage

/* design/plc_in_stage.sv */
// Input register: unpacks the slave stream into an item and holds it for the core.
module plc_in_stage
    import plc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 take,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next                = 1'b1;
            item_next.func            = func_t'(s_tuser);
            item_next.moisture        = s_tdata[11:0];
            item_next.water_mode      = water_mode_t'(s_tdata[13:12]);
            item_next.pump_request    = s_tdata[14];
            item_next.light_request   = s_tdata[15];
            item_next.countdown_hours = s_tdata[19:16];
            item_next.red_level       = s_tdata[27:20];
            item_next.green_level     = s_tdata[35:28];
            item_next.blue_level      = s_tdata[43:36];
            item_next.warm_level      = s_tdata[51:44];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

/* design/plc_core.sv */
// Pump cycle, light countdown and duty update; its state registers form the result.
module plc_core
    import plc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [THRESH_W-1:0]   cfg_data,
    input  logic                  item_valid,
    input  item_t                 item,
    output logic                  take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [THRESH_W-1:0] thr_low_reg, thr_med_reg, thr_high_reg;
    logic [THRESH_W-1:0] limit;

    logic       out_valid_reg, out_valid_next;
    logic       resting_reg, resting_next;
    logic [4:0] count_reg, count_next;
    logic       running_reg, running_next;
    logic [9:0] minutes_reg, minutes_next;
    logic       expiry_reg, expiry_next;
    logic       pump_reg, pump_next;
    logic       light_reg, light_next;
    logic [9:0] duty_r_reg, duty_r_next;
    logic [9:0] duty_g_reg, duty_g_next;
    logic [9:0] duty_b_reg, duty_b_next;
    logic [9:0] duty_w_reg, duty_w_next;
    logic [9:0] armed_minutes;

    assign take     = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, minutes_reg, duty_w_reg, duty_b_reg, duty_g_reg, duty_r_reg,
                       light_reg, pump_reg};

    assign armed_minutes = 10'({item.countdown_hours, 6'b0}) - 10'({item.countdown_hours, 2'b0});

    always_comb begin
        unique case (item.water_mode)
            MODE_LOW:    limit = thr_low_reg;
            MODE_MEDIUM: limit = thr_med_reg;
            default:     limit = thr_high_reg;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        resting_next   = resting_reg;
        count_next     = count_reg;
        running_next   = running_reg;
        minutes_next   = minutes_reg;
        expiry_next    = expiry_reg;
        pump_next      = pump_reg;
        light_next     = light_reg;
        duty_r_next    = duty_r_reg;
        duty_g_next    = duty_g_reg;
        duty_b_next    = duty_b_reg;
        duty_w_next    = duty_w_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (take) begin
            out_valid_next = 1'b1;
            if (item.func == FUNC_STEP) begin
                duty_r_next = duty_of(item.red_level);
                duty_g_next = duty_of(item.green_level);
                duty_b_next = duty_of(item.blue_level);
                duty_w_next = duty_of(item.warm_level);

                if (resting_reg) begin
                    pump_next  = 1'b0;
                    count_next = 5'(count_reg + 5'd1);
                    if (count_next > REST_LAST) begin
                        resting_next = 1'b0;
                        count_next   = 5'd0;
                    end
                end

                if (item.water_mode == MODE_MANUAL) begin
                    count_next   = 5'd0;
                    resting_next = 1'b0;
                    pump_next    = item.pump_request;
                end else if (item.moisture > limit) begin
                    if (!resting_next) begin
                        pump_next  = 1'b1;
                        count_next = 5'(count_next + 5'd1);
                        if (count_next > RUN_LAST) begin
                            resting_next = 1'b1;
                        end
                    end
                end else begin
                    pump_next = 1'b0;
                end

                // a zero setting clears the latched expiry; latched expiry reads as cancel
                if (item.countdown_hours == 4'd0) begin
                    expiry_next = 1'b0;
                end
                if (item.countdown_hours != 4'd0 && !expiry_reg) begin
                    if (!running_reg) begin
                        minutes_next = armed_minutes;
                        running_next = 1'b1;
                    end
                    light_next = 1'b1;
                end else begin
                    running_next = 1'b0;
                    minutes_next = 10'd0;
                    light_next   = item.light_request;
                end
            end else if (running_reg) begin
                minutes_next = minutes_reg - 10'd1;
                if (minutes_next == 10'd0) begin
                    running_next = 1'b0;
                    expiry_next  = 1'b1;
                    light_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_low_reg   <= THRESH_LOW_RST;
            thr_med_reg   <= THRESH_MED_RST;
            thr_high_reg  <= THRESH_HIGH_RST;
            out_valid_reg <= 1'b0;
            resting_reg   <= 1'b0;
            count_reg     <= 5'd0;
            running_reg   <= 1'b0;
            minutes_reg   <= 10'd0;
            expiry_reg    <= 1'b0;
            pump_reg      <= 1'b0;
            light_reg     <= 1'b0;
            duty_r_reg    <= 10'd0;
            duty_g_reg    <= 10'd0;
            duty_b_reg    <= 10'd0;
            duty_w_reg    <= 10'd0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_THRESH_LOW:  thr_low_reg  <= cfg_data;
                    REG_THRESH_MED:  thr_med_reg  <= cfg_data;
                    REG_THRESH_HIGH: thr_high_reg <= cfg_data;
                    default: ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            resting_reg   <= resting_next;
            count_reg     <= count_next;
            running_reg   <= running_next;
            minutes_reg   <= minutes_next;
            expiry_reg    <= expiry_next;
            pump_reg      <= pump_next;
            light_reg     <= light_next;
            duty_r_reg    <= duty_r_next;
            duty_g_reg    <= duty_g_next;
            duty_b_reg    <= duty_b_next;
            duty_w_reg    <= duty_w_next;
        end
    end

endmodule

/* design/planter_pump_and_light_controller.sv */
// An input transfer is registered in plc_in_stage, then taken into the plc_core state registers that drive m_tvalid.
// One transfer per cycle while m_tready stays high, set by the update in plc_core.
// While a result waits on m_tready the input register takes one more item, then stalls.
// Reset (aresetn low, synchronous): thresholds 3000/2300/1800, pump and light off,
// countdown stopped, duties zero, no item held.
module planter_pump_and_light_controller
    import plc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [THRESH_W-1:0]   cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // moisture, water_mode, pump_request, light_request, countdown_hours,
    // red_level, green_level, blue_level, warm_level, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pump_on, light_enable, red_duty, green_duty, blue_duty, warm_duty,
    // minutes_remaining, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic  take;
    logic  item_valid;
    item_t item;

    plc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    plc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* design/plc_checker.sv */
// Port-level checks for the planter controller, bound to the top level.
`include "planter_pump_and_light_controller_assert.svh"

module plc_checker
    import plc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    `PLC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PLC_ASSERT_NOW(a_minutes_range, aclk, aresetn, m_tvalid, m_tdata[51:42] <= 10'd900)
    `PLC_ASSERT_NOW(a_light_while_counting, aclk, aresetn, m_tvalid && m_tdata[51:42] != 10'd0, m_tdata[1])
    `PLC_ASSERT_NOW(a_duty_range, aclk, aresetn, m_tvalid, m_tdata[11:2] <= 10'd1000 && m_tdata[21:12] <= 10'd1000 && m_tdata[31:22] <= 10'd1000 && m_tdata[41:32] <= 10'd1000)
    `PLC_ASSERT_NEXT(a_accept_after_drain, aclk, aresetn, !m_tvalid && !s_tvalid, s_tready)

endmodule

bind planter_pump_and_light_controller plc_checker u_plc_checker (.*);
